// ----- hw/rtl/semver_pkg.sv -----
// ----------------------------------------------------------------------------
// semver_pkg
// Shared types and constants for the semantic version string validator.
// ----------------------------------------------------------------------------
package semver_pkg;

	// Width of the reported number fields
	localparam int OUT_W = 31;

	// Parser section codes
	typedef enum logic [2:0] {
		SEC_MAJOR = 3'd0,
		SEC_MINOR = 3'd1,
		SEC_PATCH = 3'd2,
		SEC_PRE   = 3'd3,
		SEC_BUILD = 3'd4
	} sec_t;

	// Character codes
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	// Identifier length counter saturates here
	localparam logic [1:0] LEN_SAT = 2'd2;

	// One result item
	typedef struct packed {
		logic             valid_res;
		logic [OUT_W-1:0] major_number;
		logic [OUT_W-1:0] minor_number;
		logic [OUT_W-1:0] patch_number;
		logic             has_prerelease;
		logic             has_build;
	} res_t;

endpackage

// ----- hw/rtl/semver_in_reg.sv -----
// ----------------------------------------------------------------------------
// semver_in_reg
// Input register: captures one character item and holds it until the
// parse core consumes it.
// ----------------------------------------------------------------------------
module semver_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       last,
	input  logic       can_load,
	output logic       advance,
	output logic [7:0] char_s1,
	output logic       last_s1
);

	logic valid_s1;

	// A non-final item always moves on; a final one needs room at the output
	assign advance  = valid_s1 && (!last_s1 || can_load);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= character;
			last_s1 <= last;
		end
	end

	// A final item blocked by a full output stays put
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled item in input register changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

endmodule

// ----- hw/rtl/semver_parse_core.sv -----
// ----------------------------------------------------------------------------
// semver_parse_core
// Parser state and single-step update: one character per enable, with the
// finished result formed combinationally on the final character.
// ----------------------------------------------------------------------------
module semver_parse_core #(
	parameter int NUMBER_WIDTH = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic [7:0]          char_s1,
	input  logic                last_s1,
	output semver_pkg::res_t    res
);

	localparam int XW = (NUMBER_WIDTH > semver_pkg::OUT_W) ? NUMBER_WIDTH
		: semver_pkg::OUT_W;

	semver_pkg::sec_t        sec_q, n_sec;
	logic [NUMBER_WIDTH-1:0] acc_q, n_acc;
	logic [NUMBER_WIDTH-1:0] maj_q, n_maj;
	logic [NUMBER_WIDTH-1:0] min_q, n_min;
	logic [1:0]              len_q, n_len;
	logic                    fz_q, n_fz;
	logic                    snd_q, n_snd;
	logic                    err_q, n_err;
	logic                    pre_q, n_pre;
	logic                    f_err;

	logic                    is_dig, is_let, is_hy, is_dot, is_plus, is_zero;
	logic [1:0]              len_bump;
	logic [NUMBER_WIDTH+3:0] acc_ext, acc_x10;
	logic                    ovf;
	logic [XW-1:0]           maj_x, min_x, pat_x;

	// Character classes
	assign is_dig  = (char_s1 >= semver_pkg::CH_ZERO) && (char_s1 <= semver_pkg::CH_NINE);
	assign is_let  = ((char_s1 >= semver_pkg::CH_UP_A) && (char_s1 <= semver_pkg::CH_UP_Z))
		|| ((char_s1 >= semver_pkg::CH_LO_A) && (char_s1 <= semver_pkg::CH_LO_Z));
	assign is_hy   = (char_s1 == semver_pkg::CH_HYPHEN);
	assign is_dot  = (char_s1 == semver_pkg::CH_DOT);
	assign is_plus = (char_s1 == semver_pkg::CH_PLUS);
	assign is_zero = (char_s1 == semver_pkg::CH_ZERO);

	assign len_bump = (len_q < semver_pkg::LEN_SAT) ? len_q + 2'd1 : len_q;

	// acc*10 + digit by shift-add; any bit above the number width is overflow
	assign acc_ext = {4'b0000, acc_q};
	assign acc_x10 = (acc_ext << 3) + (acc_ext << 1)
		+ {{NUMBER_WIDTH{1'b0}}, char_s1[3:0]};
	assign ovf     = |acc_x10[NUMBER_WIDTH+3:NUMBER_WIDTH];

	// Next state for one character
	always_comb begin
		n_sec = sec_q;
		n_acc = acc_q;
		n_maj = maj_q;
		n_min = min_q;
		n_len = len_q;
		n_fz  = fz_q;
		n_snd = snd_q;
		n_err = err_q;
		n_pre = pre_q;
		case (sec_q)
			semver_pkg::SEC_MAJOR, semver_pkg::SEC_MINOR, semver_pkg::SEC_PATCH: begin
				if (is_dig) begin
					if (len_q != 2'd0 && fz_q) n_err = 1'b1;
					if (len_q == 2'd0) n_fz = is_zero;
					if (ovf) n_err = 1'b1;
					else n_acc = acc_x10[NUMBER_WIDTH-1:0];
					n_len = len_bump;
				end else if (is_dot && sec_q != semver_pkg::SEC_PATCH) begin
					if (len_q == 2'd0) n_err = 1'b1;
					if (sec_q == semver_pkg::SEC_MAJOR) begin
						n_maj = acc_q;
						n_sec = semver_pkg::SEC_MINOR;
					end else begin
						n_min = acc_q;
						n_sec = semver_pkg::SEC_PATCH;
					end
					n_acc = '0;
					n_len = 2'd0;
					n_fz  = 1'b0;
					n_snd = 1'b0;
				end else if (sec_q == semver_pkg::SEC_PATCH && (is_hy || is_plus)) begin
					if (len_q == 2'd0) n_err = 1'b1;
					n_len = 2'd0;
					n_fz  = 1'b0;
					n_snd = 1'b0;
					if (is_hy) begin
						n_sec = semver_pkg::SEC_PRE;
						n_pre = 1'b1;
					end else begin
						n_sec = semver_pkg::SEC_BUILD;
					end
				end else begin
					n_err = 1'b1;
				end
			end
			semver_pkg::SEC_PRE: begin
				if (is_dot || is_plus) begin
					// close identifier with the numeric leading-zero rule
					if (len_q == 2'd0) n_err = 1'b1;
					if (!snd_q && fz_q && len_q >= semver_pkg::LEN_SAT) n_err = 1'b1;
					n_len = 2'd0;
					n_fz  = 1'b0;
					n_snd = 1'b0;
					if (is_plus) n_sec = semver_pkg::SEC_BUILD;
				end else if (is_dig) begin
					if (len_q == 2'd0) n_fz = is_zero;
					n_len = len_bump;
				end else if (is_let || is_hy) begin
					n_snd = 1'b1;
					n_len = len_bump;
				end else begin
					n_err = 1'b1;
				end
			end
			semver_pkg::SEC_BUILD: begin
				if (is_dot) begin
					if (len_q == 2'd0) n_err = 1'b1;
					n_len = 2'd0;
					n_fz  = 1'b0;
					n_snd = 1'b0;
				end else if (is_dig || is_let || is_hy) begin
					n_len = len_bump;
				end else begin
					n_err = 1'b1;
				end
			end
			default: begin
				n_err = 1'b1;
			end
		endcase
	end

	// End-of-string checks on the updated state
	always_comb begin
		f_err = n_err;
		case (n_sec)
			semver_pkg::SEC_PATCH: begin
				if (n_len == 2'd0) f_err = 1'b1;
			end
			semver_pkg::SEC_PRE: begin
				if (n_len == 2'd0) f_err = 1'b1;
				if (!n_snd && n_fz && n_len >= semver_pkg::LEN_SAT) f_err = 1'b1;
			end
			semver_pkg::SEC_BUILD: begin
				if (n_len == 2'd0) f_err = 1'b1;
			end
			default: begin
				f_err = 1'b1;
			end
		endcase
	end

	// Result fields carry the low bits of each number
	assign maj_x = XW'(n_maj);
	assign min_x = XW'(n_min);
	assign pat_x = XW'(n_acc);

	always_comb begin
		res = '0;
		if (!f_err) begin
			res.valid_res      = 1'b1;
			res.major_number   = maj_x[semver_pkg::OUT_W-1:0];
			res.minor_number   = min_x[semver_pkg::OUT_W-1:0];
			res.patch_number   = pat_x[semver_pkg::OUT_W-1:0];
			res.has_prerelease = n_pre;
			res.has_build      = (n_sec == semver_pkg::SEC_BUILD);
		end
	end

	// State registers; the final character returns the parser to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q <= semver_pkg::SEC_MAJOR;
			acc_q <= '0;
			maj_q <= '0;
			min_q <= '0;
			len_q <= 2'd0;
			fz_q  <= 1'b0;
			snd_q <= 1'b0;
			err_q <= 1'b0;
			pre_q <= 1'b0;
		end else if (en) begin
			if (last_s1) begin
				sec_q <= semver_pkg::SEC_MAJOR;
				acc_q <= '0;
				maj_q <= '0;
				min_q <= '0;
				len_q <= 2'd0;
				fz_q  <= 1'b0;
				snd_q <= 1'b0;
				err_q <= 1'b0;
				pre_q <= 1'b0;
			end else begin
				sec_q <= n_sec;
				acc_q <= n_acc;
				maj_q <= n_maj;
				min_q <= n_min;
				len_q <= n_len;
				fz_q  <= n_fz;
				snd_q <= n_snd;
				err_q <= n_err;
				pre_q <= n_pre;
			end
		end
	end

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		en && last_s1 |=> sec_q == semver_pkg::SEC_MAJOR && len_q == 2'd0 && !err_q && !pre_q)
		else $error("parser not restarted after final character");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		en && !last_s1 && err_q |=> err_q)
		else $error("error flag dropped within a string");

endmodule

// ----- hw/rtl/semver_out_reg.sv -----
// ----------------------------------------------------------------------------
// semver_out_reg
// Result register: holds one finished result item until it is taken.
// ----------------------------------------------------------------------------
module semver_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  semver_pkg::res_t res,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output semver_pkg::res_t res_q
);

	assign can_load = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> can_load)
		else $error("result register overwritten before it was taken");

endmodule

// ----- hw/rtl/semver_string_validator_unit.sv -----
// ----------------------------------------------------------------------------
// semver_string_validator_unit
// Streaming semantic version (MAJOR.MINOR.PATCH[-pre][+build]) checker.
// ----------------------------------------------------------------------------
// Path: a final character is held in the input register until the result
// register can load, then its result is loaded into the result register.
// Throughput: one character per cycle, except that a final character waits while the result register is full.
// Reset: arst_n clears the parser state and both valid flags at once.
// ----------------------------------------------------------------------------
module semver_string_validator_unit #(
	parameter int NUMBER_WIDTH = 31
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   character,
	input  logic                         last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         valid_res,
	output logic [semver_pkg::OUT_W-1:0] major_number,
	output logic [semver_pkg::OUT_W-1:0] minor_number,
	output logic [semver_pkg::OUT_W-1:0] patch_number,
	output logic                         has_prerelease,
	output logic                         has_build
);

	logic             can_load;
	logic             advance;
	logic [7:0]       char_s1;
	logic             last_s1;
	semver_pkg::res_t res;
	semver_pkg::res_t res_q;

	semver_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.character(character),
		.last     (last),
		.can_load (can_load),
		.advance  (advance),
		.char_s1  (char_s1),
		.last_s1  (last_s1)
	);

	semver_parse_core #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.char_s1(char_s1),
		.last_s1(last_s1),
		.res    (res)
	);

	semver_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.res      (res),
		.can_load (can_load),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res_q    (res_q)
	);

	// Result fields to ports
	assign valid_res      = res_q.valid_res;
	assign major_number   = res_q.major_number;
	assign minor_number   = res_q.minor_number;
	assign patch_number   = res_q.patch_number;
	assign has_prerelease = res_q.has_prerelease;
	assign has_build      = res_q.has_build;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> major_number == '0 && minor_number == '0
			&& patch_number == '0 && !has_prerelease && !has_build)
		else $error("invalid result carries nonzero fields");

endmodule
